// ===== rtl/hmd5_pkg.sv =====
// Shared types, constants and MD5 round functions for the HMAC-MD5 authenticator.
package hmd5_pkg;

    localparam int unsigned KEY_REGS        = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned BUF_WORDS       = 16;

    localparam logic [7:0]   IPAD_BYTE      = 8'h36;
    localparam logic [7:0]   OPAD_BYTE      = 8'h5c;
    localparam logic [7:0]   PAD_MARK       = 8'h80;
    localparam logic [31:0]  OUTER_LEN_BITS = 32'h0000_0280;
    localparam logic [63:0]  PAD_LEN_BYTES  = 64'd64;
    localparam logic [5:0]   LEN_FIELD_FILL = 6'd56;
    localparam logic [127:0] MD5_IV         =
        {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    typedef enum logic [3:0]
    {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_ADD   = 4'b1000
    } state_t;

    typedef enum logic [2:0]
    {
        JOB_IPAD = 3'd0,
        JOB_DATA = 3'd1,
        JOB_FIN1 = 3'd2,
        JOB_FIN2 = 3'd3,
        JOB_OPAD = 3'd4,
        JOB_OFIN = 3'd5
    } job_t;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } queue_item_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(4'd5 * i[3:0] + 4'd1);
            2'd2: g = 4'(4'd3 * i[3:0] + 4'd5);
            2'd3: g = 4'(4'd7 * i[3:0]);
            default: g = i[3:0];
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [5:0] i, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (i[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        return (x << s) | (x >> (6'd32 - {1'b0, s}));
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// ===== rtl/hmd5_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hmd5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/hmd5_front.sv =====
// Input side: accepts message items into a short queue ahead of the hash engine.
module hmd5_front #(
    parameter int unsigned DEPTH = hmd5_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hmd5_pkg::queue_item_t in_item,
    output logic                 head_valid,
    input  logic                 head_pop,
    output hmd5_pkg::queue_item_t head_item
);
    import hmd5_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    queue_item_t    slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push;
    logic           pop;

    assign in_ready   = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule

// ===== rtl/hmd5_core.sv =====
// Hash engine: sequences pad, data and final blocks through one MD5 round per cycle.
module hmd5_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0][63:0]      key_words,
    input  logic                  head_valid,
    output logic                  head_pop,
    input  hmd5_pkg::queue_item_t head_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [63:0]           digest_word,
    output logic                  word_index,
    output logic                  last_word
);
    import hmd5_pkg::*;

    localparam int unsigned AW = $clog2(BUF_WORDS);

    state_t          state_reg, state_next;
    job_t            job_reg, job_next;
    logic [5:0]      rnd_reg, rnd_next;
    logic [AW-1:0]   g_reg, g_next;
    logic [31:0]     a_reg, b_reg, c_reg, d_reg;
    logic [31:0]     a_next, b_next, c_next, d_next;
    logic [3:0][31:0] chain_reg, chain_next;
    logic [3:0][31:0] inner_reg, inner_next;
    logic [3:0][31:0] sum;
    logic [31:0]     asm_reg, asm_next;
    logic [5:0]      fill_reg, fill_next;
    logic [63:0]     len_reg, len_next;
    logic            started_reg, started_next;
    logic            end_pend_reg, end_pend_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_idx_reg, out_idx_next;
    logic [127:0]    out_data_reg, out_data_next;

    logic            ram_wr_en;
    logic [31:0]     ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    logic [31:0]     ram_q;

    logic [63:0]     len_bits;
    logic [31:0]     key_half;
    logic [7:0]      pad_byte;
    logic [31:0]     partial;
    logic [31:0]     msg;
    logic [31:0]     round_sum;

    hmd5_ram #(
        .WIDTH (32),
        .DEPTH (BUF_WORDS)
    ) u_buf (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (fill_reg[5:2]),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    assign len_bits = {len_reg[60:0], 3'b000};
    assign pad_byte = (job_reg == JOB_IPAD) ? IPAD_BYTE : OPAD_BYTE;
    assign key_half = g_reg[0] ? key_words[g_reg[3:1]][31:0] : key_words[g_reg[3:1]][63:32];

    always_comb
    begin
        unique case (fill_reg[1:0])
            2'd0: partial = {24'h0, PAD_MARK};
            2'd1: partial = {16'h0, PAD_MARK, asm_reg[7:0]};
            2'd2: partial = {8'h0, PAD_MARK, asm_reg[15:0]};
            2'd3: partial = {PAD_MARK, asm_reg[23:0]};
            default: partial = {24'h0, PAD_MARK};
        endcase
    end

    always_comb
    begin
        msg = '0;
        unique case (job_reg)
            JOB_IPAD, JOB_OPAD:
            begin
                msg = bswap32(key_half) ^ {4{pad_byte}};
            end
            JOB_DATA:
            begin
                msg = ram_q;
            end
            JOB_FIN1:
            begin
                if (g_reg < fill_reg[5:2])
                begin
                    msg = ram_q;
                end
                else if (g_reg == fill_reg[5:2])
                begin
                    msg = partial;
                end
                else if (fill_reg < LEN_FIELD_FILL && g_reg == 4'd14)
                begin
                    msg = len_bits[31:0];
                end
                else if (fill_reg < LEN_FIELD_FILL && g_reg == 4'd15)
                begin
                    msg = len_bits[63:32];
                end
            end
            JOB_FIN2:
            begin
                if (g_reg == 4'd14)
                begin
                    msg = len_bits[31:0];
                end
                else if (g_reg == 4'd15)
                begin
                    msg = len_bits[63:32];
                end
            end
            JOB_OFIN:
            begin
                if (g_reg < 4'd4)
                begin
                    msg = inner_reg[g_reg[1:0]];
                end
                else if (g_reg == 4'd4)
                begin
                    msg = {24'h0, PAD_MARK};
                end
                else if (g_reg == 4'd14)
                begin
                    msg = OUTER_LEN_BITS;
                end
            end
            default: msg = '0;
        endcase
    end

    assign round_sum = a_reg + md5_f(rnd_reg, b_reg, c_reg, d_reg) + md5_k(rnd_reg) + msg;
    assign sum[0] = chain_reg[0] + a_reg;
    assign sum[1] = chain_reg[1] + b_reg;
    assign sum[2] = chain_reg[2] + c_reg;
    assign sum[3] = chain_reg[3] + d_reg;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        rnd_next       = rnd_reg;
        g_next         = g_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        chain_next     = chain_reg;
        inner_next     = inner_reg;
        asm_next       = asm_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        started_next   = started_reg;
        end_pend_next  = end_pend_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_data_next  = out_data_reg;
        head_pop       = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_data    = {head_item.data_byte, asm_reg[23:0]};
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;

        if (out_valid_reg && out_ready)
        begin
            out_idx_next = !out_idx_reg;
            if (out_idx_reg)
            begin
                out_valid_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && !out_valid_reg)
                begin
                    if (!started_reg)
                    begin
                        job_next   = JOB_IPAD;
                        chain_next = MD5_IV;
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        head_pop = 1'b1;
                        if (head_item.byte_valid)
                        begin
                            asm_next[8*fill_reg[1:0] +: 8] = head_item.data_byte;
                            ram_wr_en = (fill_reg[1:0] == 2'd3);
                            fill_next = 6'(fill_reg + 6'd1);
                            len_next  = len_reg + 64'd1;
                        end
                        if (head_item.byte_valid && fill_reg == 6'd63)
                        begin
                            job_next      = JOB_DATA;
                            end_pend_next = head_item.message_end;
                            state_next    = ST_SETUP;
                        end
                        else if (head_item.message_end)
                        begin
                            job_next   = JOB_FIN1;
                            state_next = ST_SETUP;
                        end
                    end
                end
            end
            ST_SETUP:
            begin
                a_next      = chain_reg[0];
                b_next      = chain_reg[1];
                c_next      = chain_reg[2];
                d_next      = chain_reg[3];
                rnd_next    = '0;
                g_next      = md5_g(6'd0);
                ram_rd_en   = 1'b1;
                ram_rd_addr = md5_g(6'd0);
                state_next  = ST_ROUND;
            end
            ST_ROUND:
            begin
                a_next      = d_reg;
                d_next      = c_reg;
                c_next      = b_reg;
                b_next      = b_reg + rotl32(round_sum, md5_rot(rnd_reg));
                rnd_next    = 6'(rnd_reg + 6'd1);
                g_next      = md5_g(6'(rnd_reg + 6'd1));
                ram_rd_en   = 1'b1;
                ram_rd_addr = md5_g(6'(rnd_reg + 6'd1));
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                chain_next = sum;
                state_next = ST_IDLE;
                unique case (job_reg)
                    JOB_IPAD:
                    begin
                        started_next = 1'b1;
                        len_next     = PAD_LEN_BYTES;
                        fill_next    = '0;
                    end
                    JOB_DATA:
                    begin
                        if (end_pend_reg)
                        begin
                            end_pend_next = 1'b0;
                            job_next      = JOB_FIN1;
                            state_next    = ST_SETUP;
                        end
                    end
                    JOB_FIN1, JOB_FIN2:
                    begin
                        state_next = ST_SETUP;
                        if (job_reg == JOB_FIN1 && fill_reg >= LEN_FIELD_FILL)
                        begin
                            job_next = JOB_FIN2;
                        end
                        else
                        begin
                            inner_next = sum;
                            chain_next = MD5_IV;
                            job_next   = JOB_OPAD;
                        end
                    end
                    JOB_OPAD:
                    begin
                        job_next   = JOB_OFIN;
                        state_next = ST_SETUP;
                    end
                    JOB_OFIN:
                    begin
                        out_data_next  = {bswap32(sum[0]), bswap32(sum[1]),
                                          bswap32(sum[2]), bswap32(sum[3])};
                        out_valid_next = 1'b1;
                        out_idx_next   = 1'b0;
                        started_next   = 1'b0;
                        fill_next      = '0;
                        len_next       = '0;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_IPAD;
            rnd_reg       <= '0;
            fill_reg      <= '0;
            len_reg       <= '0;
            started_reg   <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            rnd_reg       <= rnd_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            started_reg   <= started_next;
            end_pend_reg  <= end_pend_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg        <= g_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        chain_reg    <= chain_next;
        inner_reg    <= inner_next;
        asm_reg      <= asm_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign word_index  = out_idx_reg;
    assign last_word   = out_idx_reg;
    assign digest_word = out_idx_reg ? out_data_reg[63:0] : out_data_reg[127:64];

`ifndef SYNTH
    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && job_reg == JOB_OFIN) |-> !out_valid_reg)
        else $error("Digest produced while the previous one is still pending.");

    a_last_round_adds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("Compression did not end after the last round.");

    a_pop_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> (started_reg && state_reg == ST_IDLE))
        else $error("Item consumed before the inner pad block was absorbed.");

    a_full_block_compress: assert property (@(posedge clk) disable iff (!rst_n)
        (head_pop && head_item.byte_valid && fill_reg == 6'd63)
        |=> (state_reg == ST_SETUP && job_reg == JOB_DATA))
        else $error("A full data block was not compressed.");
`endif
endmodule

// ===== rtl/hmac_md5_authenticator_unit.sv =====
// Top level of the HMAC-MD5 authenticator: key registers, input queue and hash engine.
//
// Usage: the key is written as eight 64-bit registers through the cfg channel
// (cfg_index 0..7, first key byte in bits 63:56) while the block is idle.
// Message bytes arrive on the input channel one per item; byte_valid marks a
// real byte and message_end marks the last item of a message. After the last
// item the block returns two items on the output channel: digest bytes 0-7
// (word_index 0) and bytes 8-15 (word_index 1, last_word 1).
// Timing: one MD5 compression runs a setup state, one round per cycle in the shared
// round unit, then an add state. The first item of a message waits for the inner pad
// block; data bytes are taken one per engine cycle while the engine is idle, with a
// compression after every 64th byte. The final item is followed by the final block
// (two if 56 or more bytes remain in it), the outer pad and the outer final block.
// A queue of QUEUE_DEPTH items in front of the engine keeps accepting while
// the engine works or while the digest waits, until it is full. A stalled
// receiver holds the digest word steady; the engine takes no further item
// from the queue until both digest words have been accepted.
// Reset clears the key, the queue and all message state; no clearing pass.
module hmac_md5_authenticator_unit #(
    parameter int unsigned QUEUE_DEPTH = hmd5_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic        word_index,
    output logic        last_word
);
    import hmd5_pkg::*;

    logic [KEY_REGS-1:0][63:0] key_reg;
    queue_item_t               in_item;
    queue_item_t               head_item;
    logic                      head_valid;
    logic                      head_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    assign in_item.data_byte   = data_byte;
    assign in_item.byte_valid  = byte_valid;
    assign in_item.message_end = message_end;

    hmd5_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_item  (head_item)
    );

    hmd5_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_words   (key_reg),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .head_item   (head_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );
endmodule

// ===== bench/hmac_md5_authenticator_unit_tb.sv =====
// Self-checking testbench for the HMAC-MD5 authenticator with a built-in digest predictor.
module hmac_md5_authenticator_unit_tb;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 400;
    localparam int unsigned NUM_PHASES = 8;

    typedef bit [31:0] md5_state_t [4];
    typedef bit [7:0] md5_block_t [64];

    typedef struct {
        bit [7:0] data;
        bit       has_byte;
        bit       is_end;
        bit       drain_first;
    } msg_item_t;

    typedef struct {
        bit [63:0] word;
        bit        index;
        bit        last;
    } digest_word_t;

    localparam bit [31:0] SINE_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam bit [4:0] SHIFT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };
    localparam md5_state_t START_STATE = '{32'h67452301, 32'hefcdab89,
                                           32'h98badcfe, 32'h10325476};

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        message_end;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_word;
    logic        word_index;
    logic        last_word;

    bit [63:0]    key_shadow [8];
    md5_state_t   inner_chain;
    md5_block_t   byte_buffer;
    int unsigned  buffer_count;
    bit [63:0]    hashed_length;
    bit           message_open;

    msg_item_t    pending_items [$];
    digest_word_t expected_words [$];
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  error_count;
    int unsigned  cycle_count;
    int unsigned  items_sent;
    int unsigned  messages_done;
    int unsigned  words_checked;
    int unsigned  phase_items;

    hmac_md5_authenticator_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .byte_valid(byte_valid),
        .message_end(message_end),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .digest_word(digest_word),
        .word_index(word_index),
        .last_word(last_word)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic md5_state_t md5_block(md5_state_t h, md5_block_t blk);
        bit [31:0] m [16];
        bit [31:0] a, b, c, d, f, t, sum;
        int unsigned g;
        a = h[0];
        b = h[1];
        c = h[2];
        d = h[3];
        for (int i = 0; i < 16; i++)
        begin
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        end
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
            begin
                f = (b & c) | (~b & d);
                g = i;
            end
            else if (i < 32)
            begin
                f = (d & b) | (~d & c);
                g = (5 * i + 1) % 16;
            end
            else if (i < 48)
            begin
                f = b ^ c ^ d;
                g = (3 * i + 5) % 16;
            end
            else
            begin
                f = c ^ (b | ~d);
                g = (7 * i) % 16;
            end
            sum = a + f + SINE_TABLE[i] + m[g];
            t = d;
            d = c;
            c = b;
            b = b + ((sum << SHIFT_TABLE[(i / 16) * 4 + i % 4])
                     | (sum >> (32 - SHIFT_TABLE[(i / 16) * 4 + i % 4])));
            a = t;
        end
        h[0] += a;
        h[1] += b;
        h[2] += c;
        h[3] += d;
        return h;
    endfunction

    function automatic md5_state_t md5_close(md5_state_t h, md5_block_t tail,
                                             int unsigned n, bit [63:0] total);
        md5_block_t lo, hi;
        bit [63:0] bits;
        bits = total << 3;
        for (int i = 0; i < 64; i++)
        begin
            lo[i] = (i < n) ? tail[i] : 8'h00;
            hi[i] = 8'h00;
        end
        if (n < 56)
        begin
            lo[n] = 8'h80;
            for (int i = 0; i < 8; i++)
            begin
                lo[56 + i] = bits[8*i +: 8];
            end
            return md5_block(h, lo);
        end
        lo[n] = 8'h80;
        for (int i = 0; i < 8; i++)
        begin
            hi[56 + i] = bits[8*i +: 8];
        end
        return md5_block(md5_block(h, lo), hi);
    endfunction

    function automatic md5_block_t key_pad(bit [7:0] mask);
        md5_block_t pad;
        for (int k = 0; k < 64; k++)
        begin
            pad[k] = key_shadow[k / 8][63 - 8 * (k % 8) -: 8] ^ mask;
        end
        return pad;
    endfunction

    function automatic bit [7:0] state_byte(md5_state_t h, int unsigned k);
        return h[k / 4][8 * (k % 4) +: 8];
    endfunction

    task automatic absorb_item(bit [7:0] data, bit has_byte, bit is_end);
        md5_state_t inner, outer;
        md5_block_t dig;
        digest_word_t w;
        if (!message_open)
        begin
            inner_chain = md5_block(START_STATE, key_pad(hmd5_pkg::IPAD_BYTE));
            hashed_length = 64'd64;
            buffer_count = 0;
            message_open = 1'b1;
        end
        if (has_byte)
        begin
            byte_buffer[buffer_count] = data;
            buffer_count = (buffer_count + 1) % 64;
            hashed_length += 64'd1;
            if (buffer_count == 0)
            begin
                inner_chain = md5_block(inner_chain, byte_buffer);
            end
        end
        if (is_end)
        begin
            inner = md5_close(inner_chain, byte_buffer, buffer_count, hashed_length);
            for (int k = 0; k < 64; k++)
            begin
                dig[k] = (k < 16) ? state_byte(inner, k) : 8'h00;
            end
            outer = md5_block(START_STATE, key_pad(hmd5_pkg::OPAD_BYTE));
            outer = md5_close(outer, dig, 16, 64'd80);
            for (int n = 0; n < 2; n++)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    w.word[63 - 8 * k -: 8] = state_byte(outer, 8 * n + k);
                end
                w.index = n[0];
                w.last = (n == 1);
                expected_words.push_back(w);
            end
            message_open = 1'b0;
            messages_done++;
        end
    endtask

    task automatic report(string field, bit [63:0] got, bit [63:0] want);
        $display("mismatch on %s at cycle %0d: got %h, expected %h",
                 field, cycle_count, got, want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            byte_valid <= 1'b0;
            message_end <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_item(data_byte, byte_valid, message_end);
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0
                    && !(pending_items[0].drain_first && expected_words.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    msg_item_t it;
                    it = pending_items.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= it.data;
                    byte_valid <= it.has_byte;
                    message_end <= it.is_end;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report("unexpected digest word", digest_word, 64'd0);
                end
                else
                begin
                    digest_word_t w;
                    w = expected_words.pop_front();
                    if (digest_word !== w.word)
                        report("digest_word", digest_word, w.word);
                    if (word_index !== w.index)
                        report("word_index", word_index, w.index);
                    if (last_word !== w.last)
                        report("last_word", last_word, w.last);
                    words_checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic queue_item(bit [7:0] data, bit has_byte, bit is_end, bit drain);
        msg_item_t it;
        it.data = data;
        it.has_byte = has_byte;
        it.is_end = is_end;
        it.drain_first = drain;
        pending_items.push_back(it);
        phase_items++;
    endtask

    task automatic queue_message(int unsigned len, bit drain);
        int unsigned left;
        bit first;
        left = len;
        first = drain;
        while (left > 0)
        begin
            if ($urandom_range(99) < 8)
            begin
                queue_item($urandom_range(255), 1'b0, 1'b0, first);
            end
            else
            begin
                left--;
                queue_item($urandom_range(255), 1'b1,
                           (left == 0) && $urandom_range(1), first);
                if (left == 0 && !pending_items[$].is_end)
                    queue_item($urandom_range(255), 1'b0, 1'b1, 1'b0);
            end
            first = 1'b0;
        end
        if (len == 0)
            queue_item($urandom_range(255), 1'b0, 1'b1, drain);
    endtask

    function automatic int unsigned pick_length();
        int unsigned r;
        int unsigned edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        r = $urandom_range(99);
        if (r < 15)
            return edges[$urandom_range(9)];
        if (r < 19)
            return $urandom_range(200);
        return $urandom_range(40);
    endfunction

    task automatic load_key(int unsigned setting);
        bit [63:0] value;
        for (int r = 0; r < 8; r++)
        begin
            case (setting)
                0: value = 64'd0;
                1: value = '1;
                2: value = (r < 2) ? {$urandom, $urandom} : 64'd0;
                3: value = {$urandom, $urandom} & {8{{7'h00, 1'b0} | 8'(($urandom_range(3) != 0) ? 8'hff : 8'h00)}};
                default: value = {$urandom, $urandom};
            endcase
            key_shadow[r] = value;
            cfg_valid <= 1'b1;
            cfg_index <= r[2:0];
            cfg_data <= value;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        message_open = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_key(p % 5);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            phase_items = 0;
            if (p == 0)
            begin
                queue_item(8'h00, 1'b0, 1'b1, 1'b0);
                queue_item(8'hff, 1'b1, 1'b1, 1'b0);
                queue_item(8'h00, 1'b1, 1'b0, 1'b0);
                queue_item(8'ha5, 1'b0, 1'b1, 1'b0);
                queue_item(8'h5a, 1'b0, 1'b0, 1'b0);
                queue_item(8'h80, 1'b1, 1'b1, 1'b0);
                queue_item(8'h7f, 1'b1, 1'b0, 1'b0);
                queue_item(8'h01, 1'b1, 1'b1, 1'b0);
            end
            while (phase_items < 125)
                queue_message(pick_length(), phase_items > 60 && phase_items < 100);
            wait_idle();
        end
        $display("Checked %0d digest words from %0d messages over %0d input items,",
                 words_checked, messages_done, items_sent);
        $display("with %0d key settings and four sender/receiver idling mixes.", NUM_PHASES);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
